FILE: sv/ic_pkg.sv
package ic_pkg;

	// Sequence capacity and key width
	localparam int MAX_ITEMS  = 1024;
	localparam int VALUE_BITS = 32;

	// Item index / per-item count width (holds MAX_ITEMS itself)
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	// Result count width and saturation limit
	localparam int OUT_W = 19;
	localparam int TOT_W = OUT_W + 1;
	localparam logic [OUT_W-1:0] COUNT_MAX = {OUT_W{1'b1}};

	// Flipping the sign bit gives an unsigned key with the same ordering
	localparam logic [VALUE_BITS-1:0] KEY_FLIP = {1'b1, {(VALUE_BITS-1){1'b0}}};

	typedef struct packed {
		logic signed [31:0] value;
		logic               is_last;
	} ic_req_t;

	typedef struct packed {
		logic [OUT_W-1:0] inversion_count;
		logic             overflow;
	} ic_rsp_t;

	// Item travelling down the row of cells
	typedef struct packed {
		logic                  vld;
		logic [VALUE_BITS-1:0] key;
		logic [CNT_W-1:0]      idx;
		logic [CNT_W-1:0]      gt;
		logic                  last;
		logic                  drop;
	} ic_item_t;

endpackage

FILE: sv/ic_cell.sv
module ic_cell
	import ic_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic [CNT_W-1:0] cell_idx,
	input  ic_item_t         item_in,
	output ic_item_t         item_out
);

	logic [VALUE_BITS-1:0] stored_q;
	ic_item_t              item_q;
	logic                  live;
	logic                  hit;
	logic                  store;

	// Only cells written earlier in the same sequence take part
	assign live  = item_in.vld && !item_in.drop;
	assign hit   = live && (cell_idx < item_in.idx) && (stored_q > item_in.key);
	assign store = adv && live && (cell_idx == item_in.idx);

	// Stored key, written at most once per sequence by the item whose index matches
	always_ff @(posedge clk) begin
		if (store) begin
			stored_q <= item_in.key;
		end
	end

	// Item register, count bumped when this cell holds a greater value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q <= '0;
		end else if (adv) begin
			item_q.vld  <= item_in.vld;
			item_q.key  <= item_in.key;
			item_q.idx  <= item_in.idx;
			item_q.gt   <= item_in.gt + CNT_W'(hit);
			item_q.last <= item_in.last;
			item_q.drop <= item_in.drop;
		end
	end

	assign item_out = item_q;

endmodule

FILE: sv/ic_tail.sv
module ic_tail
	import ic_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  ic_item_t item_in,
	output logic     result_valid,
	output ic_rsp_t  result
);

	logic [OUT_W-1:0] total_q;
	logic             ovf_q;
	logic             out_valid_q;
	ic_rsp_t          out_q;
	logic [TOT_W-1:0] sum;
	logic [OUT_W-1:0] sat;
	logic             take;

	assign take = adv && item_in.vld;

	// Running total with saturation
	always_comb begin
		sum = TOT_W'(total_q) + TOT_W'(item_in.gt);
		sat = (sum > TOT_W'(COUNT_MAX)) ? COUNT_MAX : sum[OUT_W-1:0];
	end

	// Accumulator; cleared by the last item of a sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			if (item_in.last) begin
				total_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				total_q <= sat;
				ovf_q   <= ovf_q | item_in.drop;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= take && item_in.last;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (take && item_in.last) begin
			out_q.inversion_count <= sat;
			out_q.overflow        <= ovf_q | item_in.drop;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

FILE: sv/inversion_counter.sv
// Inversion counter. Signed values stream in one per request, the final one
// flagged with is_last; for that request the block returns the number of
// earlier/later pairs whose earlier value is strictly greater, plus a flag
// that is set when more than MAX_ITEMS values were sent and the extra ones
// were dropped. Each value walks a row of MAX_ITEMS cells, one cell per
// cycle while the row advances; cell k keeps the k-th value of the current
// sequence and counts it against every later value passing by. While
// item_stall is low a new request is taken every cycle, sequences may
// follow each other with no gap and no clearing pass is needed. A result
// passes through the cell row and then the result register. While a
// result is held by result_stall the whole row stands still, and
// item_stall is raised.
module inversion_counter
	import ic_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  ic_req_t item,
	output logic    result_valid,
	input  logic    result_stall,
	output ic_rsp_t result
);

	logic             adv;
	logic             accept;
	logic             full;
	logic [CNT_W-1:0] count_q;
	ic_item_t         chain [MAX_ITEMS+1];

	// Whole row moves unless a finished result is held
	assign adv        = !(result_valid && result_stall);
	assign item_stall = !adv;
	assign accept     = item_valid && adv;
	assign full       = (count_q == CNT_W'(MAX_ITEMS));

	// Entry: index within the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (item.is_last) begin
				count_q <= '0;
			end else if (!full) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Item entering the first cell
	always_comb begin
		chain[0].vld  = item_valid;
		chain[0].key  = item.value[VALUE_BITS-1:0] ^ KEY_FLIP;
		chain[0].idx  = count_q;
		chain[0].gt   = '0;
		chain[0].last = item.is_last;
		chain[0].drop = full;
	end

	// Row of compare/store cells
	for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
		ic_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.cell_idx (CNT_W'(g)),
			.item_in  (chain[g]),
			.item_out (chain[g+1])
		);
	end

	// Totals and result register
	ic_tail u_tail (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.item_in      (chain[MAX_ITEMS]),
		.result_valid (result_valid),
		.result       (result)
	);

	// Entry index never passes capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("entry index beyond capacity");

	// Once full, further non-last requests leave the index at capacity
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full && !item.is_last |=> full)
		else $error("index moved while store full");

	// A stored item cannot count more greater values than items before it
	a_gt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chain[MAX_ITEMS].vld && !chain[MAX_ITEMS].drop |->
			chain[MAX_ITEMS].gt <= chain[MAX_ITEMS].idx)
		else $error("greater count exceeds item index");

	// A dropped item carries no count
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		chain[MAX_ITEMS].vld && chain[MAX_ITEMS].drop |-> chain[MAX_ITEMS].gt == '0)
		else $error("dropped item has nonzero count");

endmodule

FILE: bench/inversion_checker.sv
`timescale 1ns / 100ps

// Watches both channels, keeps its own copy of the sequence and scores results
module inversion_checker
	import ic_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_stall,
	input  ic_req_t item,
	input  logic    result_valid,
	input  logic    result_stall,
	input  ic_rsp_t result,
	output int      errors,
	output int      pending
);

	// Shadow of the sequence held in the cell row
	logic [VALUE_BITS-1:0] seq_keys [MAX_ITEMS];
	int unsigned           seq_len     = 0;
	longint unsigned       seq_total   = 0;
	logic                  seq_dropped = 1'b0;

	// Totals owed by the block, oldest first
	ic_rsp_t totals_due [$];
	ic_rsp_t want;
	int      mismatches = 0;
	int      due_count  = 0;

	assign errors  = mismatches;
	assign pending = due_count;

	// Signed order becomes unsigned order once the sign bit is flipped
	function automatic logic [VALUE_BITS-1:0] order_key(input logic signed [31:0] v);
		logic [VALUE_BITS-1:0] k;
		k = v[VALUE_BITS-1:0];
		k[VALUE_BITS-1] = ~k[VALUE_BITS-1];
		return k;
	endfunction

	// Fold one accepted request into the running total; close out on last
	task automatic absorb_request(input ic_req_t req);
		logic [VALUE_BITS-1:0] key;
		int unsigned           greater;
		ic_rsp_t               done;
		key = order_key(req.value);
		if (seq_len < MAX_ITEMS) begin
			greater = 0;
			for (int unsigned i = 0; i < seq_len; i++)
				if (seq_keys[i] > key)
					greater++;
			seq_total += greater;
			if (seq_total > COUNT_MAX)
				seq_total = COUNT_MAX;
			seq_keys[seq_len] = key;
			seq_len++;
		end else begin
			// store full: request is dropped
			seq_dropped = 1'b1;
		end
		if (req.is_last) begin
			done.inversion_count = seq_total[OUT_W-1:0];
			done.overflow        = seq_dropped;
			totals_due.push_back(done);
			seq_len     = 0;
			seq_total   = 0;
			seq_dropped = 1'b0;
		end
	endtask

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, what);
	endtask

	// Sample both handshakes on the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len     = 0;
			seq_total   = 0;
			seq_dropped = 1'b0;
			totals_due.delete();
		end else begin
			if (item_valid && !item_stall)
				absorb_request(item);
			if (result_valid && !result_stall) begin
				if (totals_due.size() == 0) begin
					note_mismatch($sformatf("unexpected result: count %0d overflow %0b",
						result.inversion_count, result.overflow));
				end else begin
					want = totals_due.pop_front();
					if (result.inversion_count !== want.inversion_count)
						note_mismatch($sformatf("inversion_count: want %0d got %0d",
							want.inversion_count, result.inversion_count));
					if (result.overflow !== want.overflow)
						note_mismatch($sformatf("overflow: want %0b got %0b",
							want.overflow, result.overflow));
				end
			end
		end
		due_count <= totals_due.size();
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import ic_pkg::*;

	typedef enum int {
		SHAPE_WIDE,
		SHAPE_NARROW,
		SHAPE_CORNERS,
		SHAPE_RISING,
		SHAPE_FALLING
	} shape_e;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	ic_req_t item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	ic_rsp_t result;
	int      errors;
	int      pending;

	// calm turns off idling on both sides for a stretch
	bit calm       = 1'b0;
	int stall_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	inversion_counter u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	inversion_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.errors      (errors),
		.pending     (pending)
	);

	// Mostly short idle stretches, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Receiver backpressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			stall_left = pick_gap();
			result_stall <= 1'b0;
		end
	end

	function automatic logic signed [31:0] draw_value(input shape_e shape, input int idx);
		case (shape)
			SHAPE_NARROW:  return $urandom_range(0, 8) - 4;
			SHAPE_CORNERS: begin
				case ($urandom_range(0, 6))
					0:       return 32'h8000_0000;
					1:       return 32'h8000_0001;
					2:       return -1;
					3:       return 0;
					4:       return 1;
					5:       return 32'h7FFF_FFFE;
					default: return 32'h7FFF_FFFF;
				endcase
			end
			// strictly ordered, random low bits
			SHAPE_RISING:  return idx * 1048576 + int'($urandom_range(0, 1048575));
			SHAPE_FALLING: return -(idx * 1048576) - int'($urandom_range(0, 1048575));
			default:       return $urandom;
		endcase
	endfunction

	// Present one request after a random gap and hold it until taken
	task automatic push_item(input logic signed [31:0] v, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{value: v, is_last: last};
		do
			@(posedge clk);
		while (item_stall);
	endtask

	task automatic send_sequence(input int len, input shape_e shape);
		for (int i = 0; i < len; i++)
			push_item(draw_value(shape, i), i == len - 1);
	endtask

	initial begin
		int     sent;
		int     len;
		shape_e shape;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-request sequences at the extremes
		push_item(0, 1'b1);
		push_item(32'h8000_0000, 1'b1);
		// max then min, min then max
		push_item(32'h7FFF_FFFF, 1'b0);
		push_item(32'h8000_0000, 1'b1);
		push_item(32'h8000_0000, 1'b0);
		push_item(32'h7FFF_FFFF, 1'b1);
		// equal values never count
		push_item(5, 1'b0);
		push_item(5, 1'b0);
		push_item(5, 1'b1);
		// mixed signs around zero
		push_item(-1, 1'b0);
		push_item(0, 1'b0);
		push_item(-1, 1'b0);
		push_item(1, 1'b0);
		push_item(-2, 1'b1);
		// alternating bit patterns
		push_item(32'h5555_5555, 1'b0);
		push_item(32'hAAAA_AAAA, 1'b0);
		push_item(32'hFFFF_FFFF, 1'b0);
		push_item(32'h8000_0001, 1'b1);

		// random sequences, mostly short
		sent = 0;
		while (sent < 750) begin
			calm  <= ($urandom_range(0, 5) == 0);
			shape = shape_e'($urandom_range(0, 4));
			len   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			send_sequence(len, shape);
			sent += len;
			if (sent >= 375 && sent - len < 375) begin
				// strictly falling past capacity: largest total from a full
				// store, then dropped requests with the last one among them
				len = MAX_ITEMS + $urandom_range(1, 8);
				send_sequence(len, SHAPE_FALLING);
				sent += len;
			end
		end
		item_valid <= 1'b0;

		// drain, then give the row time to show any stray result
		do
			@(posedge clk);
		while (pending != 0);
		repeat (MAX_ITEMS + 64) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Hard stop in case the block hangs
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
